### rtl/core/kat_pkg.sv
// Shared types and constants for the keyframe animation timebase.
// Depends on nothing; imported by keyframe_animation_timebase.
package kat_pkg;

    localparam int unsigned CLIP_SLOTS_DEF = 16;
    localparam logic [31:0] STEP_INFINITE  = 32'hFFFF_FFFF;
    localparam logic [15:0] FRAME_MAX      = 16'hFFFF;

    typedef enum logic [1:0] {
        FN_TICK   = 2'd0,
        FN_SELECT = 2'd1,
        FN_WRITE  = 2'd2,
        FN_NONE   = 2'd3
    } t_func;

    typedef struct packed {
        t_func       func;
        logic [3:0]  clip_index;
        logic [15:0] first_frame;
        logic [15:0] last_frame;
        logic [31:0] clip_duration;
        logic        loop_enable;
        logic [31:0] render_frame;
        logic [31:0] delta_time;
    } t_in;

    typedef struct packed {
        logic        updated;
        logic [15:0] current_frame;
        logic [15:0] following_frame;
        logic [15:0] blend_factor;
    } t_out;

    typedef struct packed {
        logic [15:0] first;
        logic [15:0] last;
        logic [31:0] total;
        logic [31:0] step;
        logic        loops;
    } t_clip;

endpackage

### rtl/core/keyframe_animation_timebase.sv
// Keyframe animation timebase: clip table memory plus a shared radix-2 divider.
// Depends on kat_pkg.
//
// One item at a time. A select, an ignored code or a repeated render frame is
// handled in the idle state. A table write with last above first runs the
// divider for the frame time; an in-range write with last not above first stores
// its entry directly. A fresh tick reads the clip entry, reduces elapsed plus delta
// modulo the total, divides by the frame time and forms the blend factor, skipping
// later divisions when the total, offset or frame time is zero. The single
// shift-subtract divider serves all divisions. A finished result sits in an output
// register, so the block waits only if a previous result is still not taken.
module keyframe_animation_timebase
    import kat_pkg::*;
#(
    parameter int unsigned CLIP_SLOTS = CLIP_SLOTS_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_in  i_in,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_out o_out
);

    localparam int unsigned IDX_W = (CLIP_SLOTS > 1) ? $clog2(CLIP_SLOTS) : 1;

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_WDIV = 7'b0000010,
        S_RD   = 7'b0000100,
        S_MOD  = 7'b0001000,
        S_QDIV = 7'b0010000,
        S_FDIV = 7'b0100000,
        S_FIN  = 7'b1000000
    } t_phase;

    t_phase r_phase;

    t_clip r_mem [CLIP_SLOTS];
    t_clip r_rd;

    logic [3:0]  r_active;
    logic [31:0] r_elapsed;
    logic [31:0] r_seen;
    logic [31:0] r_delta;
    logic [15:0] r_hcur, r_hnxt, r_hfac;
    logic [31:0] r_q;
    logic [15:0] r_fac;
    logic [IDX_W-1:0] r_waddr;
    t_clip       r_wclip;

    // shared divider
    logic [31:0] r_rem;
    logic [32:0] r_quo;
    logic [31:0] r_dvs;
    logic [5:0]  r_cnt;

    logic        out_free, accept, idx_ok, out_load;
    logic        mem_we, rd_en;
    logic [IDX_W-1:0] mem_wa;
    t_clip       mem_wd;
    logic [32:0] trial, diff, sum;
    logic        ge;
    logic [16:0] span;
    logic [32:0] rsum;
    logic [15:0] real_fr, next_fr, fac_fin;

    assign out_free   = !o_out_valid || i_out_ready;
    assign o_in_ready = (r_phase == S_IDLE) && out_free;
    assign accept     = i_in_valid && o_in_ready;
    assign idx_ok     = {28'd0, i_in.clip_index} < 32'(CLIP_SLOTS);
    assign span       = {1'b0, i_in.last_frame} - {1'b0, i_in.first_frame} + 17'd1;
    // a result beat is loaded on a repeated tick or when a fresh tick finishes
    assign out_load   = (accept && i_in.func == FN_TICK && i_in.render_frame == r_seen) ||
                        (r_phase == S_FIN && out_free);

    assign trial = {r_rem, r_quo[32]};
    assign ge    = trial >= {1'b0, r_dvs};
    assign diff  = trial - {1'b0, r_dvs};
    assign sum   = {1'b0, r_elapsed} + {1'b0, r_delta};

    always_comb begin
        rsum    = {17'd0, r_rd.first} + {1'b0, r_q};
        real_fr = (rsum > {17'd0, FRAME_MAX}) ? FRAME_MAX : rsum[15:0];
        fac_fin = r_fac;
        if (real_fr >= r_rd.last) begin
            if (r_rd.loops) begin
                next_fr = r_rd.first;
            end else begin
                next_fr = r_rd.last - 16'd1;
                fac_fin = '0;
            end
        end else begin
            next_fr = real_fr + 16'd1;
        end
    end

    always_comb begin
        mem_we = 1'b0;
        mem_wa = IDX_W'(i_in.clip_index);
        mem_wd = '{first: i_in.first_frame, last: i_in.last_frame,
                   total: i_in.clip_duration, step: STEP_INFINITE,
                   loops: i_in.loop_enable};
        rd_en  = 1'b0;
        if (accept && i_in.func == FN_WRITE && idx_ok &&
                i_in.last_frame <= i_in.first_frame) begin
            mem_we = 1'b1;
        end
        if (accept && i_in.func == FN_TICK && i_in.render_frame != r_seen) begin
            rd_en = 1'b1;
        end
        if (r_phase == S_WDIV && r_cnt == '0) begin
            mem_we      = 1'b1;
            mem_wa      = r_waddr;
            mem_wd      = r_wclip;
            mem_wd.step = r_quo[31:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        if (rd_en) begin
            r_rd <= r_mem[IDX_W'(r_active)];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= S_IDLE;
            r_active    <= '0;
            r_elapsed   <= '0;
            r_seen      <= '1;
            r_hcur      <= '0;
            r_hnxt      <= '0;
            r_hfac      <= '0;
            o_out_valid <= 1'b0;
            r_cnt       <= '0;
        end else begin
            if (out_load) begin
                o_out_valid <= 1'b1;
            end else if (o_out_valid && i_out_ready) begin
                o_out_valid <= 1'b0;
            end
            // one divider step per cycle while a division runs
            if (r_cnt != '0) begin
                r_rem <= ge ? diff[31:0] : trial[31:0];
                r_quo <= {r_quo[31:0], ge};
                r_cnt <= r_cnt - 6'd1;
            end
            unique case (r_phase)
                S_IDLE: begin
                    if (accept) begin
                        case (i_in.func)
                            FN_TICK: begin
                                if (i_in.render_frame != r_seen) begin
                                    r_seen  <= i_in.render_frame;
                                    r_delta <= i_in.delta_time;
                                    r_phase <= S_RD;
                                end else begin
                                    o_out <= '{updated: 1'b0, current_frame: r_hcur,
                                               following_frame: r_hnxt,
                                               blend_factor: r_hfac};
                                end
                            end
                            FN_SELECT: begin
                                if (idx_ok) begin
                                    r_active  <= i_in.clip_index;
                                    r_elapsed <= '0;
                                end
                            end
                            FN_WRITE: begin
                                if (idx_ok && i_in.last_frame > i_in.first_frame) begin
                                    r_waddr <= IDX_W'(i_in.clip_index);
                                    r_wclip <= mem_wd;
                                    r_rem   <= '0;
                                    r_quo   <= {i_in.clip_duration, 1'b0};
                                    r_dvs   <= {15'd0, span};
                                    r_cnt   <= 6'd32;
                                    r_phase <= S_WDIV;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                S_WDIV: begin
                    if (r_cnt == '0) begin
                        r_phase <= S_IDLE;
                    end
                end
                S_RD: begin
                    if (r_rd.total == '0) begin
                        r_elapsed <= '0;
                        r_q       <= '0;
                        r_fac     <= '0;
                        r_phase   <= S_FIN;
                    end else begin
                        r_rem   <= '0;
                        r_quo   <= sum;
                        r_dvs   <= r_rd.total;
                        r_cnt   <= 6'd33;
                        r_phase <= S_MOD;
                    end
                end
                S_MOD: begin
                    if (r_cnt == '0) begin
                        r_elapsed <= r_rem;
                        r_fac     <= '0;
                        if (r_rem == '0) begin
                            r_q     <= '0;
                            r_phase <= S_FIN;
                        end else if (r_rd.step == '0) begin
                            r_q     <= 32'({1'b0, FRAME_MAX} + 17'd1);
                            r_phase <= S_FIN;
                        end else begin
                            r_quo   <= {r_rem, 1'b0};
                            r_rem   <= '0;
                            r_dvs   <= r_rd.step;
                            r_cnt   <= 6'd32;
                            r_phase <= S_QDIV;
                        end
                    end
                end
                S_QDIV: begin
                    if (r_cnt == '0) begin
                        // remainder stays, shift in sixteen zero bits
                        r_q     <= r_quo[31:0];
                        r_quo   <= '0;
                        r_cnt   <= 6'd16;
                        r_phase <= S_FDIV;
                    end
                end
                S_FDIV: begin
                    if (r_cnt == '0) begin
                        r_fac   <= r_quo[15:0];
                        r_phase <= S_FIN;
                    end
                end
                S_FIN: begin
                    if (out_free) begin
                        r_hcur      <= real_fr;
                        r_hnxt      <= next_fr;
                        r_hfac      <= fac_fin;
                        o_out <= '{updated: 1'b1, current_frame: real_fr,
                                   following_frame: next_fr, blend_factor: fac_fin};
                        r_phase     <= S_IDLE;
                    end
                end
                default: r_phase <= S_IDLE;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_rem_below_divisor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == S_WDIV || r_phase == S_MOD || r_phase == S_QDIV ||
         r_phase == S_FDIV) |-> r_rem < r_dvs)
        else $error("divider remainder not below divisor");

    a_elapsed_reduced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == S_FIN) |-> (r_rd.total == '0 || r_elapsed < r_rd.total))
        else $error("elapsed time not reduced");

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 6'd33)
        else $error("divider count out of range");

    a_idle_when_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase != S_IDLE) |-> (!o_in_ready && r_cnt == '0 || r_phase != S_RD))
        else $error("input taken while busy");
`endif

endmodule
